### rtl/core/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg
// shared widths, register codes and pipeline sideband type for the
// ray / parallelogram intersection pipeline
// ----------------------------------------------------------------------------
package rqi_pkg;

	// fixed point formats
	localparam int CW = 21;                  // coordinate width, signed Q13.8
	localparam int FB = 8;                   // fraction bits of coordinates and t
	localparam int TB = 16;                  // fraction bits of texture coordinates
	localparam int QW = CW;                  // quotient bits of every division

	// internal widths
	localparam int EW  = CW + 1;             // edge components
	localparam int JW  = CW + 3;             // corner minus origin
	localparam int XW  = 2 * EW + 1;         // edge two cross direction
	localparam int UW  = EW + JW + 1;        // edge one cross (corner minus origin)
	localparam int OA  = JW;                 // narrow operand of a wide product
	localparam int OB  = 2 * ((UW + 1) / 2); // wide operand, split in two halves
	localparam int HB  = OB / 2;
	localparam int PLW = OA + HB + 1;        // low partial product
	localparam int PHW = OA + HB;            // high partial product
	localparam int PW  = OA + OB;            // full product
	localparam int SW  = PW + 2;             // sum of three products
	localparam int RW  = SW + QW + 1;        // divider remainder
	localparam int NP  = 12;                 // wide products per triangle

	// configuration port
	localparam int AW  = 5;
	localparam int DW  = 64;
	localparam int RGW = 3 * CW;
	localparam logic [1:0] REG_CORNER   = 2'd0;
	localparam logic [1:0] REG_EDGE_ONE = 2'd1;
	localparam logic [1:0] REG_EDGE_TWO = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] t_lo;
		logic signed [CW-1:0] t_hi;
		logic                 sel;      // second triangle chosen
		logic                 bary_ok;  // chosen triangle contains the point
		logic                 m_nz;     // determinant nonzero
		logic                 rng_ok;   // t fits the quotient range
	} side_t;

endpackage

### rtl/core/rqi_front.sv
// ----------------------------------------------------------------------------
// rqi_front
// operand setup for both triangles and the first cross products
// ----------------------------------------------------------------------------
module rqi_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [rqi_pkg::CW-1:0]      origin [3],
	input  logic signed [rqi_pkg::CW-1:0]      dir [3],
	input  logic signed [rqi_pkg::CW-1:0]      t_lo,
	input  logic signed [rqi_pkg::CW-1:0]      t_hi,
	input  logic [rqi_pkg::RGW-1:0]            corner,
	input  logic [rqi_pkg::RGW-1:0]            edge_a,
	input  logic [rqi_pkg::RGW-1:0]            edge_b,
	output logic                               valid_s2,
	output logic signed [rqi_pkg::OA-1:0]      opa_s2 [2][rqi_pkg::NP],
	output logic signed [rqi_pkg::OB-1:0]      opb_s2 [2][rqi_pkg::NP],
	output rqi_pkg::side_t                     side_s2
);

	logic signed [rqi_pkg::CW-1:0] pc [3];
	logic signed [rqi_pkg::CW-1:0] sa [3];
	logic signed [rqi_pkg::CW-1:0] sb [3];
	logic signed [rqi_pkg::EW-1:0] e1_c [2][3];
	logic signed [rqi_pkg::EW-1:0] e2_c [2][3];
	logic signed [rqi_pkg::JW-1:0] ej_c [2][3];

	logic                          valid_s1;
	logic signed [rqi_pkg::EW-1:0] e1_s1 [2][3];
	logic signed [rqi_pkg::EW-1:0] e2_s1 [2][3];
	logic signed [rqi_pkg::JW-1:0] ej_s1 [2][3];
	logic signed [rqi_pkg::CW-1:0] d_s1 [3];
	rqi_pkg::side_t                side_s1;

	logic signed [rqi_pkg::XW-1:0] xp [2][3];
	logic signed [rqi_pkg::UW-1:0] up [2][3];

	// first triangle: corner, -edge one, -edge two
	// second triangle: far corner, edge two, edge one
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pc[i] = $signed(corner[i*rqi_pkg::CW +: rqi_pkg::CW]);
			sa[i] = $signed(edge_a[i*rqi_pkg::CW +: rqi_pkg::CW]);
			sb[i] = $signed(edge_b[i*rqi_pkg::CW +: rqi_pkg::CW]);
			e1_c[0][i] = -rqi_pkg::EW'(sa[i]);
			e2_c[0][i] = -rqi_pkg::EW'(sb[i]);
			e1_c[1][i] = rqi_pkg::EW'(sb[i]);
			e2_c[1][i] = rqi_pkg::EW'(sa[i]);
			ej_c[0][i] = rqi_pkg::JW'(pc[i]) - rqi_pkg::JW'(origin[i]);
			ej_c[1][i] = rqi_pkg::JW'(pc[i]) + rqi_pkg::JW'(sa[i]) + rqi_pkg::JW'(sb[i])
				- rqi_pkg::JW'(origin[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		e1_s1 <= e1_c;
		e2_s1 <= e2_c;
		ej_s1 <= ej_c;
		d_s1  <= dir;
		side_s1 <= '{t_lo: t_lo, t_hi: t_hi, default: '0};
	end

	// edge two cross direction, edge one cross offset
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			xp[k][0] = rqi_pkg::XW'(e2_s1[k][1]) * rqi_pkg::XW'(d_s1[2])
				- rqi_pkg::XW'(d_s1[1]) * rqi_pkg::XW'(e2_s1[k][2]);
			xp[k][1] = rqi_pkg::XW'(d_s1[0]) * rqi_pkg::XW'(e2_s1[k][2])
				- rqi_pkg::XW'(e2_s1[k][0]) * rqi_pkg::XW'(d_s1[2]);
			xp[k][2] = rqi_pkg::XW'(e2_s1[k][0]) * rqi_pkg::XW'(d_s1[1])
				- rqi_pkg::XW'(e2_s1[k][1]) * rqi_pkg::XW'(d_s1[0]);
			up[k][0] = rqi_pkg::UW'(e1_s1[k][0]) * rqi_pkg::UW'(ej_s1[k][1])
				- rqi_pkg::UW'(ej_s1[k][0]) * rqi_pkg::UW'(e1_s1[k][1]);
			up[k][1] = rqi_pkg::UW'(ej_s1[k][0]) * rqi_pkg::UW'(e1_s1[k][2])
				- rqi_pkg::UW'(e1_s1[k][0]) * rqi_pkg::UW'(ej_s1[k][2]);
			up[k][2] = rqi_pkg::UW'(e1_s1[k][1]) * rqi_pkg::UW'(ej_s1[k][2])
				- rqi_pkg::UW'(ej_s1[k][1]) * rqi_pkg::UW'(e1_s1[k][2]);
		end
	end

	// operand pairs: determinant, t, gamma and beta numerators
	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < 3; i++) begin
				opa_s2[k][i]     <= rqi_pkg::OA'(e1_s1[k][i]);
				opb_s2[k][i]     <= rqi_pkg::OB'(xp[k][i]);
				opa_s2[k][3 + i] <= rqi_pkg::OA'(e2_s1[k][2 - i]);
				opb_s2[k][3 + i] <= rqi_pkg::OB'(up[k][i]);
				opa_s2[k][6 + i] <= rqi_pkg::OA'(d_s1[2 - i]);
				opb_s2[k][6 + i] <= rqi_pkg::OB'(up[k][i]);
				opa_s2[k][9 + i] <= rqi_pkg::OA'(ej_s1[k][i]);
				opb_s2[k][9 + i] <= rqi_pkg::OB'(xp[k][i]);
			end
		end
	end

endmodule

### rtl/core/rqi_det.sv
// ----------------------------------------------------------------------------
// rqi_det
// wide products, determinant sums, sign fixup, triangle tests and
// selection of the dividend set
// ----------------------------------------------------------------------------
module rqi_det (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s2,
	input  logic signed [rqi_pkg::OA-1:0]      opa_s2 [2][rqi_pkg::NP],
	input  logic signed [rqi_pkg::OB-1:0]      opb_s2 [2][rqi_pkg::NP],
	input  rqi_pkg::side_t                     side_s2,
	output logic                               valid_s9,
	output logic [rqi_pkg::SW-1:0]             m_s9,
	output logic [rqi_pkg::RW-1:0]             n_s9 [3],
	output rqi_pkg::side_t                     side_s9
);

	logic                           valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	rqi_pkg::side_t                 side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [rqi_pkg::PLW-1:0] pl_s3 [2][rqi_pkg::NP];
	logic signed [rqi_pkg::PHW-1:0] ph_s3 [2][rqi_pkg::NP];
	logic signed [rqi_pkg::PW-1:0]  pr_s4 [2][rqi_pkg::NP];
	logic signed [rqi_pkg::SW-1:0]  m_s5 [2], tn_s5 [2], gn_s5 [2], bn_s5 [2];
	logic signed [rqi_pkg::SW-1:0]  m_s6 [2], tn_s6 [2], gn_s6 [2], bn_s6 [2];
	logic                           nz_s6 [2];
	logic signed [rqi_pkg::SW-1:0]  m_s7 [2], tn_s7 [2], gn_s7 [2], bn_s7 [2];
	logic                           nz_s7 [2], fail_s7 [2];
	logic [rqi_pkg::SW-1:0]         m_s8;
	logic [rqi_pkg::RW-1:0]         nt_s8, nu_s8, nv_s8;

	logic                           sel;
	logic signed [rqi_pkg::SW-1:0]  m_c, tn_c, gn_c, bn_c;
	logic                           rng;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// split products: narrow times low half, narrow times high half
	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		for (int k = 0; k < 2; k++) begin
			for (int j = 0; j < rqi_pkg::NP; j++) begin
				pl_s3[k][j] <= rqi_pkg::PLW'(opa_s2[k][j])
					* rqi_pkg::PLW'($signed({1'b0, opb_s2[k][j][rqi_pkg::HB-1:0]}));
				ph_s3[k][j] <= rqi_pkg::PHW'(opa_s2[k][j])
					* rqi_pkg::PHW'($signed(opb_s2[k][j][rqi_pkg::OB-1:rqi_pkg::HB]));
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		for (int k = 0; k < 2; k++) begin
			for (int j = 0; j < rqi_pkg::NP; j++) begin
				pr_s4[k][j] <= (rqi_pkg::PW'(ph_s3[k][j]) <<< rqi_pkg::HB)
					+ rqi_pkg::PW'(pl_s3[k][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		for (int k = 0; k < 2; k++) begin
			m_s5[k]  <= rqi_pkg::SW'(pr_s4[k][0]) + rqi_pkg::SW'(pr_s4[k][1])
				+ rqi_pkg::SW'(pr_s4[k][2]);
			tn_s5[k] <= -(rqi_pkg::SW'(pr_s4[k][3]) + rqi_pkg::SW'(pr_s4[k][4])
				+ rqi_pkg::SW'(pr_s4[k][5]));
			gn_s5[k] <= rqi_pkg::SW'(pr_s4[k][6]) + rqi_pkg::SW'(pr_s4[k][7])
				+ rqi_pkg::SW'(pr_s4[k][8]);
			bn_s5[k] <= rqi_pkg::SW'(pr_s4[k][9]) + rqi_pkg::SW'(pr_s4[k][10])
				+ rqi_pkg::SW'(pr_s4[k][11]);
		end
	end

	// make the determinant non-negative
	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		for (int k = 0; k < 2; k++) begin
			nz_s6[k] <= (m_s5[k] != '0);
			if (m_s5[k][rqi_pkg::SW-1]) begin
				m_s6[k]  <= -m_s5[k];
				tn_s6[k] <= -tn_s5[k];
				gn_s6[k] <= -gn_s5[k];
				bn_s6[k] <= -bn_s5[k];
			end else begin
				m_s6[k]  <= m_s5[k];
				tn_s6[k] <= tn_s5[k];
				gn_s6[k] <= gn_s5[k];
				bn_s6[k] <= bn_s5[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		for (int k = 0; k < 2; k++) begin
			m_s7[k]    <= m_s6[k];
			tn_s7[k]   <= tn_s6[k];
			gn_s7[k]   <= gn_s6[k];
			bn_s7[k]   <= bn_s6[k];
			nz_s7[k]   <= nz_s6[k];
			fail_s7[k] <= gn_s6[k][rqi_pkg::SW-1] || (gn_s6[k] > m_s6[k])
				|| bn_s6[k][rqi_pkg::SW-1]
				|| ((rqi_pkg::SW+1)'(bn_s6[k]) + (rqi_pkg::SW+1)'(gn_s6[k])
					> (rqi_pkg::SW+1)'(m_s6[k]));
		end
	end

	// second triangle only where the first misses on the barycentric test
	always_comb begin
		sel  = fail_s7[0];
		m_c  = sel ? m_s7[1]  : m_s7[0];
		tn_c = sel ? tn_s7[1] : tn_s7[0];
		gn_c = sel ? gn_s7[1] : gn_s7[0];
		bn_c = sel ? bn_s7[1] : bn_s7[0];
	end

	always_ff @(posedge clk) begin
		side_s8 <= '{t_lo: side_s7.t_lo, t_hi: side_s7.t_hi, sel: sel,
			bary_ok: sel ? !fail_s7[1] : !fail_s7[0],
			m_nz: sel ? nz_s7[1] : nz_s7[0], rng_ok: side_s7.rng_ok};
		m_s8  <= m_c;
		// t offset by half the quotient range so the quotient is unsigned
		nt_s8 <= (rqi_pkg::RW'(tn_c) <<< rqi_pkg::FB)
			+ (rqi_pkg::RW'(m_c) <<< (rqi_pkg::QW - 1));
		nu_s8 <= sel ? rqi_pkg::RW'(m_c - gn_c) : rqi_pkg::RW'(bn_c);
		nv_s8 <= sel ? rqi_pkg::RW'(m_c - bn_c) : rqi_pkg::RW'(gn_c);
	end

	assign rng = !nt_s8[rqi_pkg::RW-1] && (nt_s8 < (rqi_pkg::RW'(m_s8) << rqi_pkg::QW));

	always_ff @(posedge clk) begin
		side_s9 <= '{t_lo: side_s8.t_lo, t_hi: side_s8.t_hi, sel: side_s8.sel,
			bary_ok: side_s8.bary_ok, m_nz: side_s8.m_nz, rng_ok: rng};
		m_s9    <= m_s8;
		n_s9[0] <= rng ? nt_s8 : '0;
		n_s9[1] <= nu_s8 << rqi_pkg::TB;
		n_s9[2] <= nv_s8 << rqi_pkg::TB;
	end

endmodule

### rtl/core/rqi_div.sv
// ----------------------------------------------------------------------------
// rqi_div
// pipelined restoring divider, one quotient bit per stage, three
// dividends sharing one divisor
// ----------------------------------------------------------------------------
module rqi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rqi_pkg::SW-1:0]        den,
	input  logic [rqi_pkg::RW-1:0]        num [3],
	input  rqi_pkg::side_t                side_in,
	output logic                          out_valid,
	output logic [rqi_pkg::QW-1:0]        quo [3],
	output logic                          t_exact,
	output rqi_pkg::side_t                side_out
);

	logic                   vld_s  [rqi_pkg::QW];
	logic [rqi_pkg::RW-1:0] rem_s  [rqi_pkg::QW][3];
	logic [rqi_pkg::QW-1:0] quo_s  [rqi_pkg::QW][3];
	logic [rqi_pkg::SW-1:0] den_s  [rqi_pkg::QW];
	rqi_pkg::side_t         side_s [rqi_pkg::QW];

	for (genvar k = 0; k < rqi_pkg::QW; k++) begin : g_stage
		localparam int B = rqi_pkg::QW - 1 - k;
		logic                   vin;
		logic [rqi_pkg::RW-1:0] rin [3];
		logic [rqi_pkg::QW-1:0] qin [3];
		logic [rqi_pkg::SW-1:0] din;
		rqi_pkg::side_t         sin;
		logic [rqi_pkg::RW-1:0] dsh;

		if (k == 0) begin : g_first
			assign vin = in_valid;
			assign rin = num;
			assign qin = '{default: '0};
			assign din = den;
			assign sin = side_in;
		end else begin : g_next
			assign vin = vld_s[k-1];
			assign rin = rem_s[k-1];
			assign qin = quo_s[k-1];
			assign din = den_s[k-1];
			assign sin = side_s[k-1];
		end

		assign dsh = rqi_pkg::RW'(din) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			den_s[k]  <= din;
			side_s[k] <= sin;
			for (int j = 0; j < 3; j++) begin
				if (rin[j] >= dsh) begin
					rem_s[k][j] <= rin[j] - dsh;
					quo_s[k][j] <= qin[j] | (rqi_pkg::QW'(1) << B);
				end else begin
					rem_s[k][j] <= rin[j];
					quo_s[k][j] <= qin[j];
				end
			end
		end
	end

	assign out_valid = vld_s[rqi_pkg::QW-1];
	assign quo       = quo_s[rqi_pkg::QW-1];
	assign t_exact   = (rem_s[rqi_pkg::QW-1][0] == '0);
	assign side_out  = side_s[rqi_pkg::QW-1];

endmodule

### rtl/core/ray_quad_intersect.sv
// ----------------------------------------------------------------------------
// ray_quad_intersect
// ray against parallelogram test, one ray per clock, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   the parallelogram (corner, edge one, edge two) sits in three 63-bit
//   registers on the apb-style port at byte addresses 0, 8 and 16; write
//   them only while no item is in flight
//   a ray item is taken on every rising edge with start high; busy is
//   always low, so an item may enter in every cycle
//   each item gives exactly one result: done is high for one cycle with
//   hit, hit_distance, tex_u, tex_v and second_half; a miss shows zeros
// pipeline and throughput
//   31 register stages, one item per cycle sustained; the depth is set by
//   the 21-stage quotient pipeline (one bit per stage) plus two setup
//   stages, seven product/test stages and the output register
// reset
//   arst_n clears the valid flags, outputs and configuration registers
//   to zero and empties the pipeline; items in flight are dropped
// the receiver cannot stall: results leave on the done cycle
// ----------------------------------------------------------------------------
module ray_quad_intersect (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          start,
	output logic                          busy,
	input  logic signed [rqi_pkg::CW-1:0] ray_origin_x,
	input  logic signed [rqi_pkg::CW-1:0] ray_origin_y,
	input  logic signed [rqi_pkg::CW-1:0] ray_origin_z,
	input  logic signed [rqi_pkg::CW-1:0] ray_dir_x,
	input  logic signed [rqi_pkg::CW-1:0] ray_dir_y,
	input  logic signed [rqi_pkg::CW-1:0] ray_dir_z,
	input  logic signed [rqi_pkg::CW-1:0] t_lower,
	input  logic signed [rqi_pkg::CW-1:0] t_upper,
	// result channel
	output logic                          done,
	output logic                          hit,
	output logic signed [rqi_pkg::CW-1:0] hit_distance,
	output logic [rqi_pkg::TB:0]          tex_u,
	output logic [rqi_pkg::TB:0]          tex_v,
	output logic                          second_half,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rqi_pkg::AW-1:0]        paddr,
	input  logic [rqi_pkg::DW-1:0]        pwdata,
	output logic [rqi_pkg::DW-1:0]        prdata,
	output logic                          pready
);

	logic [rqi_pkg::RGW-1:0] corner_q, edge_one_q, edge_two_q;
	logic                    cfg_wr;
	logic [1:0]              cfg_idx;

	logic                           valid_s2;
	logic signed [rqi_pkg::OA-1:0]  opa_s2 [2][rqi_pkg::NP];
	logic signed [rqi_pkg::OB-1:0]  opb_s2 [2][rqi_pkg::NP];
	rqi_pkg::side_t                 side_s2;
	logic                           valid_s9;
	logic [rqi_pkg::SW-1:0]         m_s9;
	logic [rqi_pkg::RW-1:0]         n_s9 [3];
	rqi_pkg::side_t                 side_s9;
	logic                           div_valid;
	logic [rqi_pkg::QW-1:0]         quo [3];
	logic                           t_exact;
	rqi_pkg::side_t                 div_side;

	logic signed [rqi_pkg::CW-1:0]  tq;
	logic                           t_ok;
	logic                           hit_c;

	// no backpressure anywhere in the pipe
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ---------------- configuration registers ----------------
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[rqi_pkg::AW-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q   <= '0;
			edge_one_q <= '0;
			edge_two_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rqi_pkg::REG_CORNER:   corner_q   <= pwdata[rqi_pkg::RGW-1:0];
				rqi_pkg::REG_EDGE_ONE: edge_one_q <= pwdata[rqi_pkg::RGW-1:0];
				rqi_pkg::REG_EDGE_TWO: edge_two_q <= pwdata[rqi_pkg::RGW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			rqi_pkg::REG_CORNER:   prdata = rqi_pkg::DW'(corner_q);
			rqi_pkg::REG_EDGE_ONE: prdata = rqi_pkg::DW'(edge_one_q);
			rqi_pkg::REG_EDGE_TWO: prdata = rqi_pkg::DW'(edge_two_q);
			default:               prdata = '0;
		endcase
	end

	// ---------------- pipeline ----------------
	// stages 1-2: triangle operands and the narrow cross products
	rqi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.origin   ('{ray_origin_x, ray_origin_y, ray_origin_z}),
		.dir      ('{ray_dir_x, ray_dir_y, ray_dir_z}),
		.t_lo     (t_lower),
		.t_hi     (t_upper),
		.corner   (corner_q),
		.edge_a   (edge_one_q),
		.edge_b   (edge_two_q),
		.valid_s2 (valid_s2),
		.opa_s2   (opa_s2),
		.opb_s2   (opb_s2),
		.side_s2  (side_s2)
	);

	// stages 3-9: determinants, barycentric tests, triangle choice
	rqi_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.opa_s2   (opa_s2),
		.opb_s2   (opb_s2),
		.side_s2  (side_s2),
		.valid_s9 (valid_s9),
		.m_s9     (m_s9),
		.n_s9     (n_s9),
		.side_s9  (side_s9)
	);

	// quotient pipeline: t (offset), tex_u, tex_v
	rqi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s9),
		.den       (m_s9),
		.num       (n_s9),
		.side_in   (side_s9),
		.out_valid (div_valid),
		.quo       (quo),
		.t_exact   (t_exact),
		.side_out  (div_side)
	);

	// ---------------- interval test and output register ----------------
	// undo the half-range offset: flipping the top bit subtracts it
	assign tq = $signed({~quo[0][rqi_pkg::QW-1], quo[0][rqi_pkg::QW-2:0]});

	// upper bound is exclusive when t had to be rounded down onto it
	assign t_ok = div_side.rng_ok && (tq >= $signed(div_side.t_lo))
		&& ((tq < $signed(div_side.t_hi)) || ((tq == $signed(div_side.t_hi)) && t_exact));

	assign hit_c = div_valid && div_side.m_nz && div_side.bary_ok && t_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			hit          <= 1'b0;
			hit_distance <= '0;
			tex_u        <= '0;
			tex_v        <= '0;
			second_half  <= 1'b0;
		end else begin
			done         <= div_valid;
			hit          <= hit_c;
			hit_distance <= hit_c ? tq : '0;
			tex_u        <= hit_c ? quo[1][rqi_pkg::TB:0] : '0;
			tex_v        <= hit_c ? quo[2][rqi_pkg::TB:0] : '0;
			second_half  <= hit_c && div_side.sel;
		end
	end

	// ---------------- assertions ----------------
	a_hit_done : assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done) else $error("hit without done");

	a_half_hit : assert property (@(posedge clk) disable iff (!arst_n)
		second_half |-> hit) else $error("second half flagged on a miss");

	a_miss_zero : assert property (@(posedge clk) disable iff (!arst_n)
		!hit |-> (hit_distance == '0 && tex_u == '0 && tex_v == '0))
		else $error("miss with nonzero result fields");

	a_tex_range : assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (tex_u <= (rqi_pkg::TB+1)'(1 << rqi_pkg::TB)
			&& tex_v <= (rqi_pkg::TB+1)'(1 << rqi_pkg::TB)))
		else $error("texture coordinate above one");

endmodule
